>>> hdl/tccw_pkg.sv
`default_nettype none

package tccw_pkg;

    // Field widths fixed by the cell and cursor formats.
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int ADDR_W    = 11;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 8;
    localparam int WORD_W    = CHAR_W + COLOR_W;
    localparam int NUMBER_W  = 32;

    // Decimal conversion: ten BCD digits cover any 32-bit magnitude.
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
    localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
    localparam int BITCNT_W   = $clog2(NUMBER_W);

    // Grid defaults.
    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    // Attribute after reset: white on black.
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h0F;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
    localparam logic [CHAR_W-1:0] CH_ZERO      = 8'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS     = 8'd45;

    // Command codes.
    localparam logic CMD_CHAR   = 1'b0;
    localparam logic CMD_NUMBER = 1'b1;

    // One character offered to the cursor unit.
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_req;

    // Current decimal digit offered by the converter.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [DIGIT_W-1:0] digit;
    } t_digit_out;

endpackage

`default_nettype wire

>>> hdl/text_console_cell_writer.sv
// Text console cell writer.
// Input channel (i_valid / o_stall): one item per transfer, either a
// character (i_cmd = 0, i_char_code) or a signed integer (i_cmd = 1,
// i_number). Output channel (o_valid / i_stall): one cell write per
// transfer, address row * COLUMNS + column and a 16-bit cell word with the
// character in the low byte and the attribute in the high byte; o_last
// marks the final write of an item. Newline, and backspace at column 0,
// give no write at all.
// Configuration channel (i_cfg_valid / o_cfg_ready): writes the attribute
// byte; always ready, to be used while the block is idle.
// A taken character is held in the code register, then passes through
// the cursor unit into the output register. An integer is converted
// bit-serially, its leading zeros are removed, then one digit per cycle
// follows unless the receiver stalls. A sign is written while conversion
// runs. One item at a time; o_stall is high until the last character is
// registered. A receiver stall holds the output register and the
// characters behind it; conversion runs on. Reset puts the cursor at
// row 0, column 0 and the attribute at 0x0F.
`default_nettype none

module text_console_cell_writer #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic                                   i_cmd,
    input  wire logic [tccw_pkg::CHAR_W-1:0]            i_char_code,
    input  wire logic signed [tccw_pkg::NUMBER_W-1:0]   i_number,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic [tccw_pkg::ADDR_W-1:0]                 o_cell_address,
    output logic [tccw_pkg::WORD_W-1:0]                 o_cell_word,
    output logic                                        o_last,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [tccw_pkg::COLOR_W-1:0]           i_cfg_text_color
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHAR,
        S_SIGN,
        S_NUM
    } t_state;

    t_state                          r_state;
    logic [tccw_pkg::CHAR_W-1:0]     r_code;
    logic [tccw_pkg::COLOR_W-1:0]    r_color;

    logic                            w_in_accept;
    logic [tccw_pkg::NUMBER_W-1:0]   w_raw;
    logic [tccw_pkg::NUMBER_W-1:0]   w_mag;
    logic                            w_start;
    logic                            w_take;
    logic                            w_cur_ready;
    tccw_pkg::t_char_req             w_req;
    tccw_pkg::t_digit_out            w_digit;

    assign o_stall     = (r_state != S_IDLE);
    assign w_in_accept = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Attribute register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= tccw_pkg::COLOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_color <= i_cfg_text_color;
        end
    end

    // Magnitude of the integer; the most negative value maps to 2^31.
    assign w_raw   = $unsigned(i_number);
    assign w_mag   = w_raw[tccw_pkg::NUMBER_W-1] ? (~w_raw + 1'b1) : w_raw;
    assign w_start = w_in_accept && (i_cmd == tccw_pkg::CMD_NUMBER);

    tccw_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_mag   (w_mag),
        .i_take  (w_take),
        .o_digit (w_digit)
    );

    // Character offered to the cursor unit in each state.
    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_IDLE: begin
                w_req = '0;
            end
            S_CHAR: begin
                w_req.valid = 1'b1;
                w_req.code  = r_code;
                w_req.last  = 1'b1;
            end
            S_SIGN: begin
                w_req.valid = 1'b1;
                w_req.code  = tccw_pkg::CH_MINUS;
                w_req.last  = 1'b0;
            end
            S_NUM: begin
                w_req.valid = w_digit.valid;
                w_req.code  = tccw_pkg::CH_ZERO
                            + tccw_pkg::CHAR_W'(w_digit.digit);
                w_req.last  = w_digit.last;
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    assign w_take = (r_state == S_NUM) && w_digit.valid && w_cur_ready;

    tccw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (w_req),
        .o_ready        (w_cur_ready),
        .i_color        (r_color),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cell_address (o_cell_address),
        .o_cell_word    (o_cell_word),
        .o_last         (o_last)
    );

    // Item sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_code <= i_char_code;
                        if (i_cmd == tccw_pkg::CMD_CHAR) begin
                            r_state <= S_CHAR;
                        end else if (w_raw[tccw_pkg::NUMBER_W-1]) begin
                            r_state <= S_SIGN;
                        end else begin
                            r_state <= S_NUM;
                        end
                    end
                end
                S_CHAR: begin
                    if (w_cur_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SIGN: begin
                    if (w_cur_ready) begin
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    if (w_take && w_digit.last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // An accepted item blocks the input on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_stall)
        else $error("input not blocked after a transfer");

    // Digits are only consumed while the sequencer is emitting an integer.
    a_take_in_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (w_digit.valid && r_state == S_NUM))
        else $error("digit taken outside integer output");

endmodule

`default_nettype wire

>>> hdl/tccw_bcd.sv
`default_nettype none

// Bit-serial binary to decimal converter (shift and add 3), followed by
// leading-zero removal and digit-by-digit output, most significant first.
module tccw_bcd (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [tccw_pkg::NUMBER_W-1:0]   i_mag,
    input  wire logic                            i_take,
    output tccw_pkg::t_digit_out                 o_digit
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_CONV,
        B_TRIM,
        B_OUT
    } t_bstate;

    t_bstate                            r_state;
    logic [tccw_pkg::NUMBER_W-1:0]      r_bin;
    logic [tccw_pkg::BCD_W-1:0]         r_bcd;
    logic [tccw_pkg::BITCNT_W-1:0]      r_cnt;
    logic [tccw_pkg::NDIG_W-1:0]        r_ndig;
    logic [tccw_pkg::BCD_W-1:0]         w_adj;
    logic [tccw_pkg::DIGIT_W-1:0]       w_top;

    // Add 3 to every digit of 5 or more before the next shift.
    always_comb begin
        for (int i = 0; i < tccw_pkg::NUM_DIGITS; i++) begin
            if (r_bcd[i*tccw_pkg::DIGIT_W +: tccw_pkg::DIGIT_W] >= 4'd5) begin
                w_adj[i*tccw_pkg::DIGIT_W +: tccw_pkg::DIGIT_W] =
                    r_bcd[i*tccw_pkg::DIGIT_W +: tccw_pkg::DIGIT_W] + 4'd3;
            end else begin
                w_adj[i*tccw_pkg::DIGIT_W +: tccw_pkg::DIGIT_W] =
                    r_bcd[i*tccw_pkg::DIGIT_W +: tccw_pkg::DIGIT_W];
            end
        end
    end

    assign w_top = r_bcd[tccw_pkg::BCD_W-1 -: tccw_pkg::DIGIT_W];

    // Sequencer: one binary bit per cycle, then leading-zero removal, then one digit per cycle while i_take is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_start) begin
                        r_bin   <= i_mag;
                        r_bcd   <= '0;
                        r_cnt   <= '0;
                        r_state <= B_CONV;
                    end
                end
                B_CONV: begin
                    r_bcd <= {w_adj[tccw_pkg::BCD_W-2:0], r_bin[tccw_pkg::NUMBER_W-1]};
                    r_bin <= {r_bin[tccw_pkg::NUMBER_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == tccw_pkg::BITCNT_W'(tccw_pkg::NUMBER_W - 1)) begin
                        r_ndig  <= tccw_pkg::NDIG_W'(tccw_pkg::NUM_DIGITS);
                        r_state <= B_TRIM;
                    end
                end
                B_TRIM: begin
                    // Drop leading zeros but always keep the final digit.
                    if (w_top == '0 && r_ndig > tccw_pkg::NDIG_W'(1)) begin
                        r_bcd  <= {r_bcd[tccw_pkg::BCD_W-tccw_pkg::DIGIT_W-1:0],
                                   {tccw_pkg::DIGIT_W{1'b0}}};
                        r_ndig <= r_ndig - 1'b1;
                    end else begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (i_take) begin
                        r_bcd  <= {r_bcd[tccw_pkg::BCD_W-tccw_pkg::DIGIT_W-1:0],
                                   {tccw_pkg::DIGIT_W{1'b0}}};
                        r_ndig <= r_ndig - 1'b1;
                        if (r_ndig == tccw_pkg::NDIG_W'(1)) begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_digit.valid = (r_state == B_OUT);
    assign o_digit.last  = (r_ndig == tccw_pkg::NDIG_W'(1));
    assign o_digit.digit = w_top;

    // Right after trimming, the leading digit is nonzero unless it is the only one.
    a_no_leading_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_OUT && $past(r_state) == B_TRIM && r_ndig > tccw_pkg::NDIG_W'(1))
        |-> (w_top != '0))
        else $error("leading zero digit offered");

    // The digit count never runs out while digits are offered.
    a_ndig_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_OUT) |-> (r_ndig != '0))
        else $error("digit count empty in output phase");

endmodule

`default_nettype wire

>>> hdl/tccw_cursor.sv
`default_nettype none

// Cursor unit: applies the cursor rules to one character per cycle while o_ready is high and
// holds the resulting cell write in an output register.
module tccw_cursor #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tccw_pkg::t_char_req             i_req,
    output logic                                 o_ready,
    input  wire logic [tccw_pkg::COLOR_W-1:0]    i_color,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [tccw_pkg::ADDR_W-1:0]          o_cell_address,
    output logic [tccw_pkg::WORD_W-1:0]          o_cell_word,
    output logic                                 o_last
);

    localparam int PROD_W = tccw_pkg::ROW_W + tccw_pkg::COL_W;

    logic [tccw_pkg::ROW_W-1:0]   r_row;
    logic [tccw_pkg::COL_W-1:0]   r_col;
    logic                         r_out_valid;
    logic [tccw_pkg::ADDR_W-1:0]  r_addr;
    logic [tccw_pkg::WORD_W-1:0]  r_word;
    logic                         r_last;

    logic                         w_accept;
    logic                         w_is_bs;
    logic                         w_is_nl;
    logic                         w_emit;
    logic [tccw_pkg::COL_W-1:0]   w_wcol;
    logic [tccw_pkg::CHAR_W-1:0]  w_char;
    logic [PROD_W-1:0]            w_addr_full;
    logic [tccw_pkg::ROW_W-1:0]   w_row_next;
    logic [tccw_pkg::COL_W-1:0]   w_col_inc;
    logic [tccw_pkg::ROW_W-1:0]   n_row;
    logic [tccw_pkg::COL_W-1:0]   n_col;

    assign o_ready  = !r_out_valid || !i_stall;
    assign w_accept = i_req.valid && o_ready;

    // Decode the character and the cell it touches.
    assign w_is_bs   = (i_req.code == tccw_pkg::CH_BACKSPACE);
    assign w_is_nl   = (i_req.code == tccw_pkg::CH_NEWLINE);
    assign w_emit    = w_is_bs ? (r_col != '0) : !w_is_nl;
    assign w_wcol    = w_is_bs ? (r_col - 1'b1) : r_col;
    assign w_char    = w_is_bs ? tccw_pkg::CH_SPACE : i_req.code;
    assign w_addr_full = PROD_W'(r_row) * PROD_W'(COLUMNS) + PROD_W'(w_wcol);

    assign w_row_next = (r_row == tccw_pkg::ROW_W'(ROWS - 1)) ? '0 : (r_row + 1'b1);
    assign w_col_inc  = r_col + 1'b1;

    // Next cursor position.
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        priority if (w_is_bs) begin
            n_col = w_wcol;
            if (r_col == '0) begin
                n_col = r_col;
            end
        end else if (w_is_nl) begin
            n_col = '0;
            n_row = w_row_next;
        end else begin
            if (w_col_inc == tccw_pkg::COL_W'(COLUMNS)) begin
                n_col = '0;
                n_row = w_row_next;
            end else begin
                n_col = w_col_inc;
            end
        end
    end

    // Cursor registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Output register: a new write replaces the old one only after its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_addr <= w_addr_full[tccw_pkg::ADDR_W-1:0];
            r_word <= {i_color, w_char};
            r_last <= i_req.last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_cell_address = r_addr;
    assign o_cell_word    = r_word;
    assign o_last         = r_last;

    // The cursor stays on the grid.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row < tccw_pkg::ROW_W'(ROWS))
        else $error("cursor row off grid");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < tccw_pkg::COL_W'(COLUMNS))
        else $error("cursor column off grid");

endmodule

`default_nettype wire

>>> tb/text_console_cell_writer_test.sv
`timescale 1ns / 1ps

module text_console_cell_writer_test;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 500;
    localparam int PHASES        = 5;

    // One cell write as it should appear on the output channel.
    typedef struct packed {
        logic [tccw_pkg::ADDR_W-1:0] address;
        logic [tccw_pkg::WORD_W-1:0] word;
        logic                        last;
    } t_cell_write;

    logic                                 i_clk            = 1'b0;
    logic                                 i_rst_n          = 1'b0;
    logic                                 i_valid          = 1'b0;
    logic                                 i_cmd            = tccw_pkg::CMD_CHAR;
    logic [tccw_pkg::CHAR_W-1:0]          i_char_code      = '0;
    logic signed [tccw_pkg::NUMBER_W-1:0] i_number         = '0;
    logic                                 i_stall          = 1'b0;
    logic                                 i_cfg_valid      = 1'b0;
    logic [tccw_pkg::COLOR_W-1:0]         i_cfg_text_color = '0;

    logic                                 o_stall;
    logic                                 o_valid;
    logic [tccw_pkg::ADDR_W-1:0]          o_cell_address;
    logic [tccw_pkg::WORD_W-1:0]          o_cell_word;
    logic                                 o_last;
    logic                                 o_cfg_ready;

    // Cursor and attribute as the block should hold them.
    logic [tccw_pkg::ROW_W-1:0]   model_row    = '0;
    logic [tccw_pkg::COL_W-1:0]   model_column = '0;
    logic [tccw_pkg::COLOR_W-1:0] model_color  = tccw_pkg::COLOR_RESET;

    t_cell_write pending_cell_writes[$];

    int  mismatch_count   = 0;
    int  idle_cycles      = 0;
    int  burst_left       = 0;
    int  stall_left       = 0;
    bit  sender_idling    = 1'b1;
    bit  receiver_idling  = 1'b1;

    text_console_cell_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_char_code     (i_char_code),
        .i_number        (i_number),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cell_address  (o_cell_address),
        .o_cell_word     (o_cell_word),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_text_color(i_cfg_text_color)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cursor prediction
    // ------------------------------------------------------------------

    function automatic void step_row();
        if (model_row == ROWS - 1) begin
            model_row = '0;
        end else begin
            model_row = model_row + 1'b1;
        end
    endfunction

    function automatic void push_cell_write(logic [tccw_pkg::CHAR_W-1:0] code);
        t_cell_write entry;
        int          linear;
        linear        = int'(model_row) * COLUMNS + int'(model_column);
        entry.address = linear[tccw_pkg::ADDR_W-1:0];
        entry.word    = {model_color, code};
        entry.last    = 1'b0;
        pending_cell_writes.push_back(entry);
    endfunction

    // Apply one character to the cursor, queueing any cell write it causes.
    function automatic void place_char(logic [tccw_pkg::CHAR_W-1:0] code);
        if (code == tccw_pkg::CH_BACKSPACE) begin
            // Backspace blanks the cell to the left; at column 0 it does nothing.
            if (model_column != 0) begin
                model_column = model_column - 1'b1;
                push_cell_write(tccw_pkg::CH_SPACE);
            end
        end else if (code == tccw_pkg::CH_NEWLINE) begin
            model_column = '0;
            step_row();
        end else begin
            push_cell_write(code);
            if (model_column == COLUMNS - 1) begin
                model_column = '0;
                step_row();
            end else begin
                model_column = model_column + 1'b1;
            end
        end
    endfunction

    // Work out every cell write of one accepted item and flag the final one.
    function automatic void predict_cell_writes(logic cmd,
                                                logic [tccw_pkg::CHAR_W-1:0] code,
                                                logic signed [tccw_pkg::NUMBER_W-1:0] number);
        int                            first;
        int                            count;
        logic [tccw_pkg::NUMBER_W-1:0] magnitude;
        logic [tccw_pkg::DIGIT_W-1:0]  digits [tccw_pkg::NUM_DIGITS];
        t_cell_write                   tail;
        first = pending_cell_writes.size();
        if (cmd == tccw_pkg::CMD_CHAR) begin
            place_char(code);
        end else begin
            magnitude = number;
            if (number[tccw_pkg::NUMBER_W-1]) begin
                place_char(tccw_pkg::CH_MINUS);
                magnitude = ~magnitude + 1'b1;
            end
            // Digits come out least significant first and are written in reverse.
            count = 0;
            do begin
                digits[count] = tccw_pkg::DIGIT_W'(magnitude % 10);
                magnitude     = magnitude / 10;
                count++;
            end while (magnitude != 0 && count < tccw_pkg::NUM_DIGITS);
            while (count > 0) begin
                count--;
                place_char(tccw_pkg::CH_ZERO + {4'b0000, digits[count]});
            end
        end
        if (pending_cell_writes.size() > first) begin
            tail      = pending_cell_writes[pending_cell_writes.size() - 1];
            tail.last = 1'b1;
            pending_cell_writes[pending_cell_writes.size() - 1] = tail;
        end
    endfunction

    // ------------------------------------------------------------------
    // Output checking and watchdog
    // ------------------------------------------------------------------

    // Compare each output transfer with the oldest predicted cell write.
    always @(posedge i_clk) begin
        t_cell_write predicted;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_cell_writes.size() == 0) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("Unexpected cell write: address %0d word %h last %b",
                             o_cell_address, o_cell_word, o_last);
                end
                mismatch_count++;
            end else begin
                predicted = pending_cell_writes.pop_front();
                if (o_cell_address !== predicted.address || o_cell_word !== predicted.word ||
                    o_last !== predicted.last) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("Cell write mismatch: expected address %0d word %h last %b,",
                                 predicted.address, predicted.word, predicted.last,
                                 " got address %0d word %h last %b",
                                 o_cell_address, o_cell_word, o_last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver stalls in runs of random length, with an occasional long one.
    always @(negedge i_clk) begin
        if (!receiver_idling) begin
            i_stall    = 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            i_stall = !i_stall;
            if (i_stall) begin
                stall_left = ($urandom_range(0, 9) == 0) ? 14 : $urandom_range(0, 4);
            end else begin
                stall_left = $urandom_range(0, 9);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [tccw_pkg::CHAR_W-1:0] random_char();
        case ($urandom_range(0, 9))
            0, 1:    return tccw_pkg::CH_NEWLINE;
            2, 3:    return tccw_pkg::CH_BACKSPACE;
            default: return tccw_pkg::CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Integers spread over all digit counts, with the extremes mixed in.
    function automatic logic signed [tccw_pkg::NUMBER_W-1:0] random_number();
        longint                        span;
        logic [tccw_pkg::NUMBER_W-1:0] value;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'sh8000_0000;
            2: return 32'sh7FFF_FFFF;
            3: return '0;
            default: begin
                span = 1;
                repeat ($urandom_range(1, 10)) span = span * 10;
                value = tccw_pkg::NUMBER_W'(longint'($urandom) % span);
                return ($urandom_range(0, 1) == 1) ? -value : value;
            end
        endcase
    endfunction

    // Offer one item, wait for its transfer, then apply the sender's gap.
    task automatic send_item(logic cmd, logic [tccw_pkg::CHAR_W-1:0] code,
                             logic signed [tccw_pkg::NUMBER_W-1:0] number);
        int gap;
        i_cmd       = cmd;
        i_char_code = code;
        i_number    = number;
        i_valid     = 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_cell_writes(cmd, code, number);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else if (sender_idling) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(0, 16);
        end
    endtask

    task automatic send_char(logic [tccw_pkg::CHAR_W-1:0] code);
        send_item(tccw_pkg::CMD_CHAR, code, $urandom);
    endtask

    task automatic send_number(logic signed [tccw_pkg::NUMBER_W-1:0] number);
        send_item(tccw_pkg::CMD_NUMBER, tccw_pkg::CHAR_W'($urandom), number);
    endtask

    // Hold the sender off until every predicted cell write has arrived.
    task automatic drain_cell_writes();
        i_valid = 1'b0;
        while (pending_cell_writes.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drain, then allow for an item that caused no write to finish.
    task automatic wait_until_idle();
        drain_cell_writes();
        do @(posedge i_clk); while (o_stall);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_text_color(logic [tccw_pkg::COLOR_W-1:0] color);
        wait_until_idle();
        i_cfg_text_color = color;
        i_cfg_valid      = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_color = color;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default attribute after reset, and the byte extremes as characters.
    task automatic test_reset_state();
        send_char("A");
        send_char(8'h00);
        send_char(8'hFF);
    endtask

    // Attribute extremes and a mid value.
    task automatic test_text_color();
        write_text_color(8'hFF);
        send_char("B");
        write_text_color(8'h00);
        send_char("C");
        send_number(42);
        write_text_color(8'hA5);
    endtask

    // Newline, backspace at column 0 and elsewhere, and DEL as a plain byte.
    task automatic test_cursor_controls();
        send_char(tccw_pkg::CH_NEWLINE);
        send_char(tccw_pkg::CH_BACKSPACE);
        send_char("x");
        send_char(tccw_pkg::CH_BACKSPACE);
        send_char(tccw_pkg::CH_BACKSPACE);
        send_char(8'h7F);
        send_char(tccw_pkg::CH_SPACE);
    endtask

    // Zero, signs, and the largest and most negative integers.
    task automatic test_numbers();
        send_number(0);
        send_number(-1);
        send_number(7);
        send_number(32'sh8000_0000);
        send_number(32'sh7FFF_FFFF);
        send_number(1000000000);
        send_number(-999999999);
    endtask

    // Reach the last row, then overflow its columns so the row wraps to 0.
    task automatic test_grid_wrap();
        while (model_row != ROWS - 1) send_char(tccw_pkg::CH_NEWLINE);
        repeat (8) send_number(32'sh8000_0000);
    endtask

    // Random mix in phases, each with its own attribute; one phase runs
    // without idling, and every phase pauses once for all writes to land.
    task automatic test_random();
        int   phase;
        int   item;
        logic cmd;
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                write_text_color(8'h00);
            end else if (phase == 1) begin
                write_text_color(8'hFF);
            end else begin
                write_text_color(tccw_pkg::COLOR_W'($urandom));
            end
            sender_idling   = (phase != 2);
            receiver_idling = (phase != 2);
            for (item = 0; item < RANDOM_ITEMS / PHASES; item++) begin
                if (item == RANDOM_ITEMS / PHASES / 2) begin
                    drain_cell_writes();
                end
                cmd = ($urandom_range(0, 9) < 6) ? tccw_pkg::CMD_CHAR : tccw_pkg::CMD_NUMBER;
                if (cmd == tccw_pkg::CMD_CHAR) begin
                    send_item(cmd, random_char(), $urandom);
                end else begin
                    send_item(cmd, tccw_pkg::CHAR_W'($urandom), random_number());
                end
            end
        end
        sender_idling   = 1'b1;
        receiver_idling = 1'b1;
    endtask

    // Reset, run each test in turn, then report.
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_text_color();
        test_cursor_controls();
        test_numbers();
        test_grid_wrap();
        test_random();

        wait_until_idle();
        if (mismatch_count == 0 && pending_cell_writes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
